FILE: src/ffra_pkg.sv
// shared types, constants and codes of the first-fit range allocator
package ffra_pkg;

    localparam int INITIAL_SLOTS = 1024;
    localparam int MAX_SLOTS     = 65536;
    localparam int MAX_BLOCKS    = 64;

    localparam int SLOT_W = 16;
    localparam int CNT_W  = 17;
    localparam int CAP_W  = 17;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int TOT_W  = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_GROWN      = 2'd1,
        STAT_CAP_LIMIT  = 2'd2,
        STAT_TABLE_FULL = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [CAP_W-1:0] blk_end;
        logic [CAP_W-1:0] blk_size;
    } ffra_entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        ffra_entry_t      data;
    } ffra_wr_t;

endpackage

FILE: src/ffra_table.sv
// free block table: single write port, one registered read port
module ffra_table
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ffra_pkg::IDX_W-1:0] rd_addr,
    output ffra_pkg::ffra_entry_t     rd_data,
    input  ffra_pkg::ffra_wr_t        wr
);
    import ffra_pkg::*;

    ffra_entry_t mem [MAX_BLOCKS];
    ffra_entry_t mem_q_reg;
    logic        e0_valid_reg;
    logic        rd_init_reg;

    // entry 0 reads as the initial block until it is first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg <= 1'b0;
            rd_init_reg  <= 1'b0;
        end
        else
        begin
            if (wr.we && wr.addr == '0)
            begin
                e0_valid_reg <= 1'b1;
            end
            rd_init_reg <= (rd_addr == '0) && !e0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        if (rd_init_reg)
        begin
            rd_data.blk_end  = CAP_W'(INITIAL_SLOTS);
            rd_data.blk_size = CAP_W'(INITIAL_SLOTS);
        end
        else
        begin
            rd_data = mem_q_reg;
        end
    end

endmodule

FILE: src/first_fit_range_allocator.sv
// first-fit range allocator top level: request sequencer around the free block table
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done high, and it must be taken then
// since the receiver has no way to hold it. busy stays high for the whole
// request. With N free blocks in use, a request visits the table entry by
// entry, a read then a check of each entry, since the table read is
// registered; a plain allocate or free scans the table, removing a block
// adds a pass over the later entries, inserting one adds a search then a
// shift, and growth adds a step per capacity doubling. The worst case is
// reached by a free that joins its predecessor and then inserts. No
// clearing pass is needed after reset: only entries below the block count are
// ever read.
module first_fit_range_allocator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [ffra_pkg::CNT_W-1:0]  slot_count,
    input  logic [ffra_pkg::SLOT_W-1:0] slot_index,
    output logic                        done,
    output logic [ffra_pkg::SLOT_W-1:0] first_slot,
    output logic [1:0]                  status,
    output logic [ffra_pkg::CAP_W-1:0]  capacity_now
);
    import ffra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CK,
        S_GROW,
        S_GROW_END,
        S_FDEC,
        S_RM_RD,
        S_RM_WR,
        S_INS_RD,
        S_INS_CK,
        S_SH_RD,
        S_SH_WR,
        S_FIN
    } state_t;

    state_t             state_reg;
    logic               op_free_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CAP_W-1:0]   idx_reg;
    // one bit wider than a block end: a range may run far past the capacity
    logic [CAP_W:0]     key_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W:0]     newcap_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   i_reg;
    logic [TOT_W-1:0]   k_reg;
    logic [TOT_W-1:0]   pos_reg;
    logic [TOT_W-1:0]   u_reg;
    logic               u_found_reg;
    logic [1:0]         hits_reg;
    ffra_entry_t        prev_reg;
    ffra_entry_t        cur_reg;
    ffra_entry_t        last_reg;
    ffra_entry_t        ins_reg;
    logic               ins_after_reg;
    logic [SLOT_W-1:0]  slot_reg;
    status_t            stat_reg;
    logic               done_reg;
    logic [SLOT_W-1:0]  first_slot_reg;
    status_t            status_reg;
    logic [CAP_W-1:0]   capacity_now_reg;

    logic [IDX_W-1:0]   rd_addr;
    ffra_entry_t        tbl_rd;
    ffra_wr_t           tbl_wr;

    // decision terms
    logic               fit;
    logic               exact;
    logic [CAP_W-1:0]   blk_off;
    logic [CAP_W:0]     dbl;
    logic [CAP_W:0]     added;
    logic [CAP_W:0]     dbl_added;
    logic               merge_last;
    logic               has_prev;
    logic               merge_prev;
    logic               merge_next;
    logic               exists;
    logic               table_full;
    logic [CAP_W-1:0]   prev_add;
    logic [TOT_W-1:0]   k_inc;
    logic [TOT_W-1:0]   k_dec;
    logic [TOT_W-1:0]   last_idx;

    ffra_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (tbl_rd),
        .wr      (tbl_wr)
    );

    always_comb
    begin
        fit        = tbl_rd.blk_size >= cnt_reg;
        exact      = tbl_rd.blk_size == cnt_reg;
        blk_off    = tbl_rd.blk_end - tbl_rd.blk_size;
        dbl        = {newcap_reg[CAP_W-1:0], 1'b0};
        added      = newcap_reg - {1'b0, cap_reg};
        dbl_added  = dbl - {1'b0, cap_reg};
        merge_last = (total_reg != '0) && (last_reg.blk_end == cap_reg);
        has_prev   = u_reg != '0;
        merge_prev = has_prev && (prev_reg.blk_end == idx_reg);
        merge_next = (u_reg < total_reg) &&
                     (key_reg[CAP_W-1:0] == (cur_reg.blk_end - cur_reg.blk_size));
        // a hit on the merged predecessor itself does not count
        exists     = (hits_reg != 2'd0) &&
                     !(merge_prev && (prev_reg.blk_end == key_reg[CAP_W-1:0]) &&
                       (hits_reg == 2'd1));
        table_full = total_reg >= TOT_W'(MAX_BLOCKS);
        prev_add   = merge_prev ? prev_reg.blk_size : '0;
        k_inc      = k_reg + TOT_W'(1);
        k_dec      = k_reg - TOT_W'(1);
        last_idx   = total_reg - TOT_W'(1);
    end

    // table port steering
    always_comb
    begin
        rd_addr     = i_reg[IDX_W-1:0];
        tbl_wr.we   = 1'b0;
        tbl_wr.addr = k_reg[IDX_W-1:0];
        tbl_wr.data = tbl_rd;
        case (state_reg)
            S_SCAN_RD:
            begin
                rd_addr = i_reg[IDX_W-1:0];
            end
            S_SCAN_CK:
            begin
                // shrink the first fitting block in place
                if (!op_free_reg && fit && !exact)
                begin
                    tbl_wr.we            = 1'b1;
                    tbl_wr.addr          = i_reg[IDX_W-1:0];
                    tbl_wr.data.blk_end  = tbl_rd.blk_end;
                    tbl_wr.data.blk_size = tbl_rd.blk_size - cnt_reg;
                end
            end
            S_GROW_END:
            begin
                if (merge_last)
                begin
                    tbl_wr.we            = 1'b1;
                    tbl_wr.addr          = last_idx[IDX_W-1:0];
                    tbl_wr.data.blk_end  = newcap_reg[CAP_W-1:0];
                    tbl_wr.data.blk_size = last_reg.blk_size + added[CAP_W-1:0] - cnt_reg;
                end
            end
            S_FDEC:
            begin
                if (key_reg <= {1'b0, cap_reg} && merge_next)
                begin
                    tbl_wr.we            = 1'b1;
                    tbl_wr.addr          = u_reg[IDX_W-1:0];
                    tbl_wr.data.blk_end  = cur_reg.blk_end;
                    tbl_wr.data.blk_size = cur_reg.blk_size + cnt_reg + prev_add;
                end
            end
            S_RM_RD:
            begin
                rd_addr = k_inc[IDX_W-1:0];
            end
            S_RM_WR:
            begin
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = k_reg[IDX_W-1:0];
                tbl_wr.data = tbl_rd;
            end
            S_INS_RD:
            begin
                rd_addr = pos_reg[IDX_W-1:0];
            end
            S_SH_RD:
            begin
                rd_addr = k_dec[IDX_W-1:0];
                if (k_reg == pos_reg)
                begin
                    tbl_wr.we   = 1'b1;
                    tbl_wr.addr = pos_reg[IDX_W-1:0];
                    tbl_wr.data = ins_reg;
                end
            end
            S_SH_WR:
            begin
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = k_reg[IDX_W-1:0];
                tbl_wr.data = tbl_rd;
            end
            default:
            begin
                rd_addr = i_reg[IDX_W-1:0];
            end
        endcase
    end

    // request sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            total_reg        <= TOT_W'(1);
            cap_reg          <= CAP_W'(INITIAL_SLOTS);
            done_reg         <= 1'b0;
            first_slot_reg   <= '0;
            status_reg       <= STAT_OK;
            capacity_now_reg <= '0;
            op_free_reg      <= 1'b0;
            cnt_reg          <= '0;
            idx_reg          <= '0;
            key_reg          <= '0;
            newcap_reg       <= '0;
            i_reg            <= '0;
            k_reg            <= '0;
            pos_reg          <= '0;
            u_reg            <= '0;
            u_found_reg      <= 1'b0;
            hits_reg         <= '0;
            ins_after_reg    <= 1'b0;
            slot_reg         <= '0;
            stat_reg         <= STAT_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_free_reg <= cmd == CMD_FREE;
                        cnt_reg     <= slot_count;
                        idx_reg     <= {1'b0, slot_index};
                        key_reg     <= {2'b0, slot_index} + {1'b0, slot_count};
                        i_reg       <= '0;
                        u_found_reg <= 1'b0;
                        hits_reg    <= '0;
                        slot_reg    <= '0;
                        stat_reg    <= STAT_OK;
                        state_reg   <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    if (i_reg == total_reg)
                    begin
                        if (op_free_reg)
                        begin
                            if (!u_found_reg)
                            begin
                                u_reg <= total_reg;
                            end
                            state_reg <= S_FDEC;
                        end
                        else
                        begin
                            newcap_reg <= {1'b0, cap_reg};
                            state_reg  <= S_GROW;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CK;
                    end
                end
                S_SCAN_CK:
                begin
                    if (!op_free_reg)
                    begin
                        if (fit)
                        begin
                            slot_reg <= blk_off[SLOT_W-1:0];
                            if (exact)
                            begin
                                k_reg         <= i_reg;
                                ins_after_reg <= 1'b0;
                                state_reg     <= S_RM_RD;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        else
                        begin
                            last_reg  <= tbl_rd;
                            i_reg     <= i_reg + TOT_W'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        if (!u_found_reg)
                        begin
                            if (tbl_rd.blk_end > idx_reg)
                            begin
                                u_found_reg <= 1'b1;
                                u_reg       <= i_reg;
                                cur_reg     <= tbl_rd;
                            end
                            else
                            begin
                                prev_reg <= tbl_rd;
                            end
                        end
                        if (tbl_rd.blk_end == key_reg[CAP_W-1:0] && hits_reg != 2'd2)
                        begin
                            hits_reg <= hits_reg + 2'd1;
                        end
                        i_reg     <= i_reg + TOT_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_GROW:
                begin
                    // one doubling per cycle
                    if (dbl > (CAP_W+1)'(MAX_SLOTS))
                    begin
                        stat_reg  <= STAT_CAP_LIMIT;
                        slot_reg  <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        newcap_reg <= dbl;
                        if (dbl_added > {1'b0, cnt_reg})
                        begin
                            state_reg <= S_GROW_END;
                        end
                    end
                end
                S_GROW_END:
                begin
                    if (merge_last)
                    begin
                        slot_reg  <= SLOT_W'(last_reg.blk_end - last_reg.blk_size);
                        cap_reg   <= newcap_reg[CAP_W-1:0];
                        stat_reg  <= STAT_GROWN;
                        state_reg <= S_FIN;
                    end
                    else if (table_full)
                    begin
                        stat_reg  <= STAT_TABLE_FULL;
                        slot_reg  <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        slot_reg         <= cap_reg[SLOT_W-1:0];
                        cap_reg          <= newcap_reg[CAP_W-1:0];
                        stat_reg         <= STAT_GROWN;
                        ins_reg.blk_end  <= newcap_reg[CAP_W-1:0];
                        ins_reg.blk_size <= added[CAP_W-1:0] - cnt_reg;
                        pos_reg          <= '0;
                        state_reg        <= S_INS_RD;
                    end
                end
                S_FDEC:
                begin
                    ins_reg.blk_end  <= key_reg[CAP_W-1:0];
                    ins_reg.blk_size <= cnt_reg + prev_add;
                    pos_reg          <= '0;
                    k_reg            <= u_reg - TOT_W'(1);
                    if (key_reg > {1'b0, cap_reg})
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (merge_next)
                    begin
                        ins_after_reg <= 1'b0;
                        state_reg     <= merge_prev ? S_RM_RD : S_FIN;
                    end
                    else if (!merge_prev && !exists && table_full)
                    begin
                        stat_reg  <= STAT_TABLE_FULL;
                        state_reg <= S_FIN;
                    end
                    else if (merge_prev)
                    begin
                        ins_after_reg <= !exists;
                        state_reg     <= S_RM_RD;
                    end
                    else
                    begin
                        state_reg <= exists ? S_FIN : S_INS_RD;
                    end
                end
                S_RM_RD:
                begin
                    if (k_inc >= total_reg)
                    begin
                        total_reg <= total_reg - TOT_W'(1);
                        state_reg <= ins_after_reg ? S_INS_RD : S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_RM_WR;
                    end
                end
                S_RM_WR:
                begin
                    k_reg     <= k_inc;
                    state_reg <= S_RM_RD;
                end
                S_INS_RD:
                begin
                    if (pos_reg == total_reg)
                    begin
                        k_reg     <= total_reg;
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_CK;
                    end
                end
                S_INS_CK:
                begin
                    if (tbl_rd.blk_end < ins_reg.blk_end)
                    begin
                        pos_reg   <= pos_reg + TOT_W'(1);
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        k_reg     <= total_reg;
                        state_reg <= S_SH_RD;
                    end
                end
                S_SH_RD:
                begin
                    if (k_reg == pos_reg)
                    begin
                        total_reg <= total_reg + TOT_W'(1);
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_SH_WR;
                    end
                end
                S_SH_WR:
                begin
                    k_reg     <= k_dec;
                    state_reg <= S_SH_RD;
                end
                S_FIN:
                begin
                    done_reg         <= 1'b1;
                    first_slot_reg   <= slot_reg;
                    status_reg       <= stat_reg;
                    capacity_now_reg <= cap_reg;
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // prev, cur, last and insert payload need no reset
    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign first_slot   = first_slot_reg;
    assign status       = status_reg;
    assign capacity_now = capacity_now_reg;

endmodule

FILE: src/ffra_checker.sv
// port-level checks of the allocator, bound to the top level
module ffra_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [ffra_pkg::SLOT_W-1:0] first_slot,
    input logic [1:0]                  status,
    input logic [ffra_pkg::CAP_W-1:0]  capacity_now
);
    import ffra_pkg::*;

    // an accepted request keeps the block busy next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    // each result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // refused requests report slot zero
    a_refused_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_CAP_LIMIT || status == STAT_TABLE_FULL)) |-> first_slot == '0)
        else $error("refused request with nonzero slot");

    // capacity never reported as zero
    a_cap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> capacity_now != '0)
        else $error("zero capacity reported");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (.*);
